### hw/rtl/x11sp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x11sp_pkg
// Shared types and codes for the connection-setup request parser.
// ----------------------------------------------------------------------------
package x11sp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 16;
    localparam int unsigned KindW  = 3;

    localparam logic [ByteW-1:0] CH_MSB_FIRST = 8'h42; // 'B'
    localparam logic [ByteW-1:0] CH_LSB_FIRST = 8'h6C; // 'l'

    localparam logic [KindW-1:0] KIND_NONE      = 3'd0;
    localparam logic [KindW-1:0] KIND_MAJOR     = 3'd1;
    localparam logic [KindW-1:0] KIND_MINOR     = 3'd2;
    localparam logic [KindW-1:0] KIND_NAME_LEN  = 3'd3;
    localparam logic [KindW-1:0] KIND_DATA_LEN  = 3'd4;
    localparam logic [KindW-1:0] KIND_NAME_BYTE = 3'd5;
    localparam logic [KindW-1:0] KIND_DATA_BYTE = 3'd6;

    typedef struct packed {
        logic [KindW-1:0]  item_kind;
        logic [ValueW-1:0] item_value;
        logic              msb_first;
        logic              order_warning;
        logic              setup_done;
    } result_t;

endpackage

### hw/rtl/x11sp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x11sp_parse_core
// Phase machine: decodes one registered byte per step into a result.
// ----------------------------------------------------------------------------
module x11sp_parse_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    output x11sp_pkg::result_t     res
);
    import x11sp_pkg::*;

    typedef enum logic [3:0] {
        PH_ORDER    = 4'd0,
        PH_UNUSED1  = 4'd1,
        PH_MAJ0     = 4'd2,
        PH_MAJ1     = 4'd3,
        PH_MIN0     = 4'd4,
        PH_MIN1     = 4'd5,
        PH_NLEN0    = 4'd6,
        PH_NLEN1    = 4'd7,
        PH_DLEN0    = 4'd8,
        PH_DLEN1    = 4'd9,
        PH_UNUSED2  = 4'd10,
        PH_NAME     = 4'd11,
        PH_NAME_PAD = 4'd12,
        PH_DATA     = 4'd13,
        PH_DATA_PAD = 4'd14
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              msb_reg, msb_next;
    logic              warn_reg, warn_next;
    logic [ByteW-1:0]  held_reg, held_next;
    logic [ValueW-1:0] count_reg, count_next;
    logic [ValueW-1:0] name_len_reg, name_len_next;
    logic [ValueW-1:0] data_len_reg, data_len_next;

    logic [ValueW-1:0] count_inc;
    logic [ValueW-1:0] sec_len;
    logic [ValueW-1:0] pair_value;
    logic [2:0]        name_pad;
    logic [2:0]        data_pad;
    logic [3:0]        enter_from;
    logic              do_enter;
    phase_t            enter_phase;
    logic              enter_done;

    assign count_inc  = count_reg + 16'd1;
    assign name_pad   = 3'd4 - {1'b0, name_len_reg[1:0]};
    assign data_pad   = 3'd4 - {1'b0, data_len_reg[1:0]};
    assign pair_value = msb_reg ? {held_reg, rx_byte} : {rx_byte, held_reg};

    // after the unused pair the name comes next, otherwise the section after this one
    assign enter_from = (phase_reg == PH_UNUSED2) ? 4'(PH_NAME) : 4'(phase_reg) + 4'd1;

    always_comb begin
        case (phase_reg)
            PH_NAME:     sec_len = name_len_reg;
            PH_NAME_PAD: sec_len = {13'd0, name_pad};
            PH_DATA:     sec_len = data_len_reg;
            PH_DATA_PAD: sec_len = {13'd0, data_pad};
            default:     sec_len = '0;
        endcase
    end

    // first non-empty section at or after enter_from, else back to idle
    always_comb begin
        enter_done  = 1'b0;
        if (enter_from <= 4'(PH_NAME) && name_len_reg != '0) begin
            enter_phase = PH_NAME;
        end else if (enter_from <= 4'(PH_NAME_PAD) && name_len_reg[1:0] != 2'd0) begin
            enter_phase = PH_NAME_PAD;
        end else if (enter_from <= 4'(PH_DATA) && data_len_reg != '0) begin
            enter_phase = PH_DATA;
        end else if (enter_from <= 4'(PH_DATA_PAD) && data_len_reg[1:0] != 2'd0) begin
            enter_phase = PH_DATA_PAD;
        end else begin
            enter_phase = PH_ORDER;
            enter_done  = 1'b1;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        msb_next      = msb_reg;
        warn_next     = warn_reg;
        held_next     = held_reg;
        count_next    = '0;
        name_len_next = name_len_reg;
        data_len_next = data_len_reg;
        do_enter      = 1'b0;
        res.item_kind  = KIND_NONE;
        res.item_value = '0;

        case (phase_reg)
            PH_UNUSED1: phase_next = PH_MAJ0;
            PH_MAJ0: begin
                held_next  = rx_byte;
                phase_next = PH_MAJ1;
            end
            PH_MAJ1: begin
                res.item_kind  = KIND_MAJOR;
                res.item_value = pair_value;
                phase_next     = PH_MIN0;
            end
            PH_MIN0: begin
                held_next  = rx_byte;
                phase_next = PH_MIN1;
            end
            PH_MIN1: begin
                res.item_kind  = KIND_MINOR;
                res.item_value = pair_value;
                phase_next     = PH_NLEN0;
            end
            PH_NLEN0: begin
                held_next  = rx_byte;
                phase_next = PH_NLEN1;
            end
            PH_NLEN1: begin
                res.item_kind  = KIND_NAME_LEN;
                res.item_value = pair_value;
                name_len_next  = pair_value;
                phase_next     = PH_DLEN0;
            end
            PH_DLEN0: begin
                held_next  = rx_byte;
                phase_next = PH_DLEN1;
            end
            PH_DLEN1: begin
                res.item_kind  = KIND_DATA_LEN;
                res.item_value = pair_value;
                data_len_next  = pair_value;
                phase_next     = PH_UNUSED2;
            end
            PH_UNUSED2: begin
                count_next = count_inc;
                do_enter   = (count_inc >= 16'd2);
            end
            PH_NAME, PH_NAME_PAD, PH_DATA, PH_DATA_PAD: begin
                if (phase_reg == PH_NAME) begin
                    res.item_kind  = KIND_NAME_BYTE;
                    res.item_value = {8'd0, rx_byte};
                end else if (phase_reg == PH_DATA) begin
                    res.item_kind  = KIND_DATA_BYTE;
                    res.item_value = {8'd0, rx_byte};
                end
                count_next = count_inc;
                do_enter   = (count_inc >= sec_len);
            end
            default: begin
                // byte-order byte; the unreachable code 15 lands here too
                msb_next   = (rx_byte == CH_MSB_FIRST);
                warn_next  = (rx_byte != CH_MSB_FIRST) && (rx_byte != CH_LSB_FIRST);
                phase_next = PH_UNUSED1;
            end
        endcase

        if (do_enter) begin
            phase_next = enter_phase;
            count_next = '0;
        end

        res.msb_first     = msb_next;
        res.order_warning = warn_next;
        res.setup_done    = do_enter && enter_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_ORDER;
            msb_reg      <= 1'b0;
            warn_reg     <= 1'b0;
            held_reg     <= '0;
            count_reg    <= '0;
            name_len_reg <= '0;
            data_len_reg <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            msb_reg      <= msb_next;
            warn_reg     <= warn_next;
            held_reg     <= held_next;
            count_reg    <= count_next;
            name_len_reg <= name_len_next;
            data_len_reg <= data_len_next;
        end
    end

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.setup_done |=> phase_reg == PH_ORDER)
        else $error("setup_done without return to byte-order phase");

    a_order_then_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_ORDER |=> phase_reg == PH_UNUSED1)
        else $error("byte-order byte not followed by unused byte phase");

    a_string_byte_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (res.item_kind == KIND_NAME_BYTE || res.item_kind == KIND_DATA_BYTE)
        |-> res.item_value[15:8] == 8'd0)
        else $error("string byte result wider than a byte");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.item_kind == KIND_NONE |-> res.item_value == '0)
        else $error("consumed-only result carries a value");

endmodule

### hw/rtl/x11sp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x11sp_out_stage
// Result register with valid; frees itself in the cycle its beat is taken.
// ----------------------------------------------------------------------------
module x11sp_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  x11sp_pkg::result_t     load_data,
    input  logic                   m_ready,
    output logic                   can_load,
    output logic                   m_valid,
    output x11sp_pkg::result_t     m_data
);
    import x11sp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            data_reg <= load_data;
        end
    end

endmodule

### hw/rtl/x11_setup_request_parser.sv
`timescale 1ns / 1ps
// An accepted byte waits in the input register, is decoded when the result
// register is free, and is shown from there. Throughput: one byte per cycle
// unless m_ready stalls; the phase machine updates once per byte.
// Reset (aresetn low, synchronous) empties both stages and returns the parser to
// waiting for a byte-order byte with all lengths and flags cleared.
// ----------------------------------------------------------------------------
// x11_setup_request_parser
// Byte-serial parser for the client connection-setup request.
// ----------------------------------------------------------------------------
module x11_setup_request_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_item_kind,
    output logic [15:0] m_item_value,
    output logic        m_msb_first,
    output logic        m_order_warning,
    output logic        m_setup_done
);
    import x11sp_pkg::*;

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             out_can_load;
    logic             advance;
    result_t          core_res;
    result_t          out_data;

    // a beat moves from the input register into the result register
    assign advance = in_valid_reg && out_can_load;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    x11sp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res     (core_res)
    );

    x11sp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_data (core_res),
        .m_ready   (m_ready),
        .can_load  (out_can_load),
        .m_valid   (m_valid),
        .m_data    (out_data)
    );

    assign m_item_kind     = out_data.item_kind;
    assign m_item_value    = out_data.item_value;
    assign m_msb_first     = out_data.msb_first;
    assign m_order_warning = out_data.order_warning;
    assign m_setup_done    = out_data.setup_done;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the connection-setup request parser: a short
// directed table, then random setup requests (mostly well formed, some junk)
// fed byte by byte under bursty input and stalling output, every result beat
// checked against a behavioral parser kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module tb;

    import x11sp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int HOLD_AT      = 200;
    localparam int PAUSE_AT     = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    // parser phases
    localparam logic [3:0] PH_ORDER    = 4'd0;
    localparam logic [3:0] PH_UNUSED1  = 4'd1;
    localparam logic [3:0] PH_MAJOR_1  = 4'd2;
    localparam logic [3:0] PH_MAJOR_2  = 4'd3;
    localparam logic [3:0] PH_MINOR_2  = 4'd5;
    localparam logic [3:0] PH_NLEN_1   = 4'd6;
    localparam logic [3:0] PH_NLEN_2   = 4'd7;
    localparam logic [3:0] PH_DLEN_1   = 4'd8;
    localparam logic [3:0] PH_DLEN_2   = 4'd9;
    localparam logic [3:0] PH_UNUSED2  = 4'd10;
    localparam logic [3:0] PH_NAME     = 4'd11;
    localparam logic [3:0] PH_NAME_PAD = 4'd12;
    localparam logic [3:0] PH_DATA     = 4'd13;
    localparam logic [3:0] PH_DATA_PAD = 4'd14;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_item_kind;
    logic [15:0] m_item_value;
    logic        m_msb_first;
    logic        m_order_warning;
    logic        m_setup_done;

    // shadow parser state
    logic [3:0]  pr_phase;
    logic        pr_msb;
    logic        pr_warn;
    logic [7:0]  pr_held;
    logic [15:0] pr_count;
    logic [15:0] pr_name_len;
    logic [15:0] pr_data_len;

    // plan for the setup being generated
    logic [15:0] plan_name;
    logic [15:0] plan_data;

    result_t     pending_items[$];
    stim_row_t   directed_rows[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          hold_req    = 1'b0;

    x11_setup_request_parser u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_item_value    (m_item_value),
        .m_msb_first     (m_msb_first),
        .m_order_warning (m_order_warning),
        .m_setup_done    (m_setup_done)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic [15:0] pad_len(input logic [15:0] len);
        pad_len = (len[1:0] == 2'd0) ? 16'd0 : 16'(4 - int'(len[1:0]));
    endfunction

    function automatic logic [15:0] section_size(input int ph);
        case (ph)
            int'(PH_NAME):     section_size = pr_name_len;
            int'(PH_NAME_PAD): section_size = pad_len(pr_name_len);
            int'(PH_DATA):     section_size = pr_data_len;
            int'(PH_DATA_PAD): section_size = pad_len(pr_data_len);
            default:           section_size = 16'd0;
        endcase
    endfunction

    // skip empty sections; none_left means the request is complete
    task automatic enter_section(input int from, output bit none_left);
        int p;
        pr_count  = 16'd0;
        pr_phase  = PH_ORDER;
        none_left = 1'b1;
        for (p = from; p <= int'(PH_DATA_PAD); p++) begin
            if (section_size(p) != 16'd0) begin
                pr_phase  = 4'(p);
                none_left = 1'b0;
                break;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, output result_t r);
        bit done;
        done = 1'b0;
        r    = '0;
        if (pr_phase == PH_ORDER || pr_phase > PH_DATA_PAD) begin
            pr_msb   = (b == CH_MSB_FIRST);
            pr_warn  = (b != CH_MSB_FIRST) && (b != CH_LSB_FIRST);
            pr_phase = PH_UNUSED1;
            pr_count = 16'd0;
        end else if (pr_phase == PH_UNUSED1) begin
            pr_phase = PH_MAJOR_1;
        end else if (pr_phase < PH_UNUSED2) begin
            if (!pr_phase[0]) begin
                pr_held = b;
            end else begin
                r.item_value = pr_msb ? {pr_held, b} : {b, pr_held};
                case (pr_phase)
                    PH_MAJOR_2: r.item_kind = KIND_MAJOR;
                    PH_MINOR_2: r.item_kind = KIND_MINOR;
                    PH_NLEN_2: begin
                        r.item_kind = KIND_NAME_LEN;
                        pr_name_len = r.item_value;
                    end
                    default: begin
                        r.item_kind = KIND_DATA_LEN;
                        pr_data_len = r.item_value;
                    end
                endcase
            end
            pr_phase = pr_phase + 4'd1;
            pr_count = 16'd0;
        end else if (pr_phase == PH_UNUSED2) begin
            pr_count = pr_count + 16'd1;
            if (pr_count >= 16'd2) enter_section(int'(PH_NAME), done);
        end else begin
            if (pr_phase == PH_NAME) begin
                r.item_kind  = KIND_NAME_BYTE;
                r.item_value = {8'h00, b};
            end else if (pr_phase == PH_DATA) begin
                r.item_kind  = KIND_DATA_BYTE;
                r.item_value = {8'h00, b};
            end
            pr_count = pr_count + 16'd1;
            if (pr_count >= section_size(int'(pr_phase)))
                enter_section(int'(pr_phase) + 1, done);
        end
        r.msb_first     = pr_msb;
        r.order_warning = pr_warn;
        r.setup_done    = done;
    endtask

    function automatic result_t mk_result(input logic [2:0] kind, input logic [15:0] value,
                                          input logic msb, input logic warn, input logic done);
        result_t r;
        r.item_kind     = kind;
        r.item_value    = value;
        r.msb_first     = msb;
        r.order_warning = warn;
        r.setup_done    = done;
        return r;
    endfunction

    task automatic add_row(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t want = '0);
        stim_row_t row;
        row.rx    = b;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return 16'($urandom_range(0, 7));
        if (r < 19) return 16'($urandom_range(8, 40));
        return 16'($urandom_range(41, 300));
    endfunction

    // next byte of a random setup, chosen from where the parser stands
    function automatic logic [7:0] next_stim_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case (pr_phase)
            PH_ORDER: begin
                if ($urandom_range(0, 6) == 0) begin
                    // junk setup: any order byte, short random lengths
                    plan_name = 16'($urandom_range(0, 31));
                    plan_data = 16'($urandom_range(0, 31));
                end else begin
                    b = $urandom_range(0, 1) ? CH_MSB_FIRST : CH_LSB_FIRST;
                    plan_name = pick_len();
                    plan_data = pick_len();
                end
            end
            PH_NLEN_1: b = pr_msb ? plan_name[15:8] : plan_name[7:0];
            PH_NLEN_2: b = pr_msb ? plan_name[7:0]  : plan_name[15:8];
            PH_DLEN_1: b = pr_msb ? plan_data[15:8] : plan_data[7:0];
            PH_DLEN_2: b = pr_msb ? plan_data[7:0]  : plan_data[15:8];
            default: ;
        endcase
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        result_t got;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        decode_byte(b, got);
        pending_items.push_back(typed ? want : got);
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_items.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_items.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got kind %0d value %0h",
                         $time, m_item_kind, m_item_value);
                mismatches++;
            end else begin
                want = pending_items.pop_front();
                check_field("item_kind", 16'(want.item_kind), 16'(m_item_kind));
                check_field("item_value", want.item_value, m_item_value);
                check_field("msb_first", 16'(want.msb_first), 16'(m_msb_first));
                check_field("order_warning", 16'(want.order_warning), 16'(m_order_warning));
                check_field("setup_done", 16'(want.setup_done), 16'(m_setup_done));
            end
        end
    end

    initial begin : receiver
        int mode;
        int left;
        int held;
        mode    = 0;
        left    = 0;
        held    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && held < HOLD_CYCLES) begin
                // long hold-off so the parser backs up into its input
                m_ready <= 1'b0;
                held++;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(5, 60);
                end
                left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (cycle_count % 3 == 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : sender
        int n;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_rx_byte   = 8'h00;
        pr_phase    = PH_ORDER;
        pr_msb      = 1'b0;
        pr_warn     = 1'b0;
        pr_held     = 8'h00;
        pr_count    = 16'd0;
        pr_name_len = 16'd0;
        pr_data_len = 16'd0;
        plan_name   = 16'd0;
        plan_data   = 16'd0;

        // msb-first setup, extreme major, both lengths zero: ends on second unused byte
        add_row(CH_MSB_FIRST, 1, mk_result(KIND_NONE, 16'h0000, 1, 0, 0));
        add_row(8'h00, 1, mk_result(KIND_NONE, 16'h0000, 1, 0, 0));
        add_row(8'hFF, 1, mk_result(KIND_NONE, 16'h0000, 1, 0, 0));
        add_row(8'hFF, 1, mk_result(KIND_MAJOR, 16'hFFFF, 1, 0, 0));
        add_row(8'h00, 1, mk_result(KIND_NONE, 16'h0000, 1, 0, 0));
        add_row(8'h00, 1, mk_result(KIND_MINOR, 16'h0000, 1, 0, 0));
        add_row(8'h00, 1, mk_result(KIND_NONE, 16'h0000, 1, 0, 0));
        add_row(8'h00, 1, mk_result(KIND_NAME_LEN, 16'h0000, 1, 0, 0));
        add_row(8'h00, 1, mk_result(KIND_NONE, 16'h0000, 1, 0, 0));
        add_row(8'h00, 1, mk_result(KIND_DATA_LEN, 16'h0000, 1, 0, 0));
        add_row(8'hFF, 1, mk_result(KIND_NONE, 16'h0000, 1, 0, 0));
        add_row(8'hFF, 1, mk_result(KIND_NONE, 16'h0000, 1, 0, 1));
        // bad order byte falls back to lsb-first; one name byte, padding, no data
        add_row(8'h00, 1, mk_result(KIND_NONE, 16'h0000, 0, 1, 0));
        add_row(8'hAA);
        add_row(8'h0B);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h55);
        add_row(8'h55);
        add_row(8'h78);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'hFF);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        wait_for_drain();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == PAUSE_AT) wait_for_drain();
            send_byte(next_stim_byte(), 1'b0, result_t'('0));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_items.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/x11sp_pkg.sv
hw/rtl/x11sp_parse_core.sv
hw/rtl/x11sp_out_stage.sv
hw/rtl/x11_setup_request_parser.sv
tb/tb.sv
